// File: rtl/kdop_pkg.sv
// ----------------------------------------------------------------------------
// kdop_pkg
// shared constants and types of the plane-set containment test core
// ----------------------------------------------------------------------------
package kdop_pkg;

	localparam int unsigned MaxPlanesDefault = 32;
	localparam int unsigned PlaneWidth       = 128;
	localparam int unsigned CoordWidth       = 32;
	localparam int unsigned DistWidth        = 66;

	localparam logic [2:0] ModeWrite   = 3'd0;
	localparam logic [2:0] ModePoint   = 3'd1;
	localparam logic [2:0] ModeSegment = 3'd2;
	localparam logic [2:0] ModeSphere  = 3'd3;
	localparam logic [2:0] ModeBox     = 3'd4;

	localparam logic [1:0] VolNormal   = 2'd0;
	localparam logic [1:0] VolEmpty    = 2'd1;
	localparam logic [1:0] VolInfinite = 2'd2;

	localparam logic [0:0] CfgPlaneCount = 1'b0;
	localparam logic [0:0] CfgVolumeKind = 1'b1;

	localparam logic [2:0] FlagsFull     = 3'b111;
	localparam logic [2:0] FlagsPossible = 3'b001;
	localparam logic [2:0] FlagsNone     = 3'b000;

	// floor of a Q32.32 product to Q.30
	function automatic logic signed [61:0] floor_q30(input logic signed [63:0] p);
		floor_q30 = p[63:2];
	endfunction

endpackage

// File: rtl/kdop_ram.sv
// ----------------------------------------------------------------------------
// kdop_ram
// generic single-port-write, registered-read synchronous memory
// ----------------------------------------------------------------------------
module kdop_ram #(
	parameter int unsigned Width = 128,
	parameter int unsigned Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/kdop_plane_set_containment_test_core.sv
// ----------------------------------------------------------------------------
// kdop_plane_set_containment_test_core
// plane table and per-plane containment test for points, segments,
// spheres and boxes
// ----------------------------------------------------------------------------
// Usage: s_axis carries one item per transaction; mode selects a plane write
// (no result) or a query. A query walks the planes 0..plane_count-1 (at most
// MAX_PLANES of them) one at a time from the plane memory; each plane takes
// one corner per cycle through a single dot-product unit (3 multipliers,
// then an adder stage). A point or sphere takes 1 corner, a segment 2, a box
// 8 corners per plane. For each plane the memory is read, the corners are
// issued and the two pipeline stages drain; a query stops at the first plane
// that rejects it. Empty and infinite volumes and a zero plane count answer
// without reading any plane. One item is in work at a time; s_axis_tready
// is low while a query is in progress or its result waits. The result is
// held in the m_axis register until taken; a stalled receiver holds the
// block. Reset clears control state and the configuration registers; the
// plane memory is undefined until written. cfg writes are accepted at any
// cycle.
// ----------------------------------------------------------------------------
module kdop_plane_set_containment_test_core
	import kdop_pkg::*;
#(
	parameter int unsigned MAX_PLANES = MaxPlanesDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// mode[2:0], plane_index[7:3], ax[39:8], ay[71:40], az[103:72], aw[135:104],
	// bx[167:136], by[199:168], bz[231:200]
	input  logic [231:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// intersect_flags[2:0]
	output logic [7:0]   m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_data
);

	localparam int unsigned AW = $clog2(MAX_PLANES);
	localparam int unsigned CW = $clog2(MAX_PLANES + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_CORNER, ST_DRAIN, ST_OUT
	} state_t;

	state_t state_q;
	logic [5:0] plane_count_q;
	logic [1:0] volume_kind_q;
	logic [2:0] mode_q;
	logic signed [31:0] ax_q, ay_q, az_q, aw_q, bx_q, by_q, bz_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] plane_q;
	logic [2:0] corner_q;
	logic [2:0] flags_q;
	logic all_in_q, all_out_q;
	logic [7:0] out_q;
	logic out_valid_q;

	// input field views
	logic [2:0]  in_mode;
	logic [4:0]  in_index;
	assign in_mode  = s_axis_tdata[2:0];
	assign in_index = s_axis_tdata[7:3];

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= '0;
			volume_kind_q <= VolNormal;
		end else if (cfg_valid) begin
			case (cfg_index)
				CfgPlaneCount: plane_count_q <= cfg_data[5:0];
				CfgVolumeKind: volume_kind_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// plane memory
	logic            ram_we;
	logic [AW-1:0]   ram_raddr;
	logic [127:0]    ram_rdata;
	logic            s_acc;
	assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign ram_we = s_acc && (in_mode == ModeWrite) && (32'(in_index) < MAX_PLANES);
	assign ram_raddr = plane_q[AW-1:0];

	kdop_ram #(.Width(PlaneWidth), .Depth(MAX_PLANES)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(in_index)),
		.wdata({s_axis_tdata[135:104], s_axis_tdata[103:72],
			s_axis_tdata[71:40], s_axis_tdata[39:8]}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// corner point selection
	logic [2:0] ncorners;
	logic signed [31:0] px, py, pz;
	always_comb begin
		case (mode_q)
			ModeSegment: ncorners = 3'd1;
			ModeBox:     ncorners = 3'd7;
			default:     ncorners = 3'd0;
		endcase
		if (mode_q == ModeSegment) begin
			px = corner_q[0] ? bx_q : ax_q;
			py = corner_q[0] ? by_q : ay_q;
			pz = corner_q[0] ? bz_q : az_q;
		end else begin
			px = corner_q[0] ? bx_q : ax_q;
			py = corner_q[1] ? by_q : ay_q;
			pz = corner_q[2] ? bz_q : az_q;
		end
	end

	// stage 1: products
	logic signed [63:0] mx_s1, my_s1, mz_s1;
	logic signed [31:0] d_s1;
	logic v_s1, last_s1, endp_s1;
	// stage 2: distance
	logic signed [DistWidth-1:0] dist_s2;
	logic v_s2, last_s2, endp_s2;
	logic signed [DistWidth-1:0] r_q;

	logic issue, plane_done;
	assign issue = (state_q == ST_CORNER);
	assign plane_done = issue && (corner_q == ncorners);

	always_ff @(posedge clk) begin
		mx_s1 <= $signed(ram_rdata[31:0])  * px;
		my_s1 <= $signed(ram_rdata[63:32]) * py;
		mz_s1 <= $signed(ram_rdata[95:64]) * pz;
		d_s1  <= $signed(ram_rdata[127:96]);
		dist_s2 <= DistWidth'(floor_q30(mx_s1)) + DistWidth'(floor_q30(my_s1))
			+ DistWidth'(floor_q30(mz_s1)) + (DistWidth'(d_s1) <<< 14);
		last_s1 <= plane_done;
		endp_s1 <= plane_done && (plane_q + 1'b1 == n_q);
		last_s2 <= last_s1;
		endp_s2 <= endp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// per-corner verdict and plane decision
	logic pos, neg_in;
	logic c_in, c_out, reject;
	logic [2:0] new_flags;
	always_comb begin
		pos = (dist_s2 > 0);
		neg_in = (dist_s2 < 0);
		c_in = all_in_q && neg_in;
		c_out = all_out_q && !neg_in;
		reject = 1'b0;
		new_flags = flags_q;
		case (mode_q)
			ModePoint: reject = pos;
			ModeSegment: reject = !all_in_q && pos;
			ModeSphere: begin
				reject = dist_s2 > r_q;
				if (dist_s2 > -r_q) new_flags = flags_q & 3'b011;
			end
			ModeBox: begin
				reject = c_out;
				if (!c_in) new_flags = flags_q & 3'b011;
			end
			default: ;
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q <= '0;
			plane_q <= '0;
			corner_q <= '0;
			n_q <= '0;
			mode_q <= ModePoint;
			flags_q <= FlagsFull;
			all_in_q <= 1'b1;
			all_out_q <= 1'b1;
		end else begin
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			// corner verdicts before the last one of a plane, as they leave the pipeline
			if (v_s2 && !last_s2) begin
				all_in_q <= c_in || (mode_q == ModeSegment && !pos);
				all_out_q <= c_out;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc && in_mode != ModeWrite && in_mode <= ModeBox) begin
						mode_q <= in_mode;
						plane_q <= '0;
						corner_q <= '0;
						all_in_q <= 1'b1;
						all_out_q <= 1'b1;
						n_q <= (32'(plane_count_q) > MAX_PLANES) ? CW'(MAX_PLANES)
							: CW'(plane_count_q);
						flags_q <= (in_mode == ModeSegment) ? FlagsPossible : FlagsFull;
						if (volume_kind_q == VolEmpty) begin
							out_q <= {5'd0, FlagsNone};
							state_q <= ST_OUT;
						end else if (volume_kind_q == VolInfinite) begin
							out_q <= {5'd0, FlagsFull};
							state_q <= ST_OUT;
						end else if (plane_count_q == '0) begin
							out_q <= {5'd0, (in_mode == ModeSegment) ? FlagsPossible
								: FlagsFull};
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_CORNER;
				ST_CORNER: begin
					if (plane_done) begin
						corner_q <= '0;
						state_q <= ST_DRAIN;
					end else begin
						corner_q <= corner_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (v_s2 && last_s2) begin
						all_in_q <= 1'b1;
						all_out_q <= 1'b1;
						if (reject) begin
							out_q <= {5'd0, FlagsNone};
							state_q <= ST_OUT;
						end else if (endp_s2) begin
							out_q <= {5'd0, new_flags};
							state_q <= ST_OUT;
						end else begin
							flags_q <= new_flags;
							plane_q <= plane_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// segment start verdict uses all_in_q as "start point not in front"
	always_ff @(posedge clk) begin
		if (s_acc) begin
			ax_q <= $signed(s_axis_tdata[39:8]);
			ay_q <= $signed(s_axis_tdata[71:40]);
			az_q <= $signed(s_axis_tdata[103:72]);
			aw_q <= $signed(s_axis_tdata[135:104]);
			bx_q <= $signed(s_axis_tdata[167:136]);
			by_q <= $signed(s_axis_tdata[199:168]);
			bz_q <= $signed(s_axis_tdata[231:200]);
		end
		r_q <= DistWidth'(aw_q) <<< 14;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_plane_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORNER) |-> (plane_q < n_q)) else $error("plane beyond count");

endmodule

// File: tb/kdop_containment_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kdop_containment_checker
// watches the item, result and register channels of the containment core,
// keeps its own plane table and registers, works out the flags of every
// accepted query and compares them in order with the results taken
// ----------------------------------------------------------------------------
module kdop_containment_checker
	import kdop_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [231:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [7:0]   m_axis_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_data,
	output int           fail_count,
	output int           flags_pending,
	output int           flags_checked
);

	localparam int unsigned NumPlanes = MaxPlanesDefault;

	logic signed [31:0] norm_x [NumPlanes];
	logic signed [31:0] norm_y [NumPlanes];
	logic signed [31:0] norm_z [NumPlanes];
	logic signed [31:0] offset [NumPlanes];
	logic [5:0]         used_planes;
	logic [1:0]         vol_kind;
	logic [2:0]         expected_flags [$];

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	// signed distance in Q.30: each product floored, offset scaled up
	function automatic logic signed [65:0] plane_distance(input int p,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z);
		logic signed [63:0] px, py, pz;
		logic signed [65:0] s;
		px = norm_x[p] * x;
		py = norm_y[p] * y;
		pz = norm_z[p] * z;
		s = px >>> 2;
		s = s + (py >>> 2);
		s = s + (pz >>> 2);
		s = s + offset[p] * 66'sd16384;
		return s;
	endfunction

	function automatic logic [2:0] containment_flags(input logic [2:0] mode,
			input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic signed [31:0] az, input logic signed [31:0] aw,
			input logic signed [31:0] bx, input logic signed [31:0] by,
			input logic signed [31:0] bz);
		int n;
		logic [2:0] flags;
		logic signed [65:0] pl_dist, radius;
		logic all_in, all_out;
		logic signed [31:0] cx, cy, cz;
		n = (used_planes > NumPlanes) ? NumPlanes : used_planes;
		if (vol_kind == VolEmpty)
			return FlagsNone;
		if (vol_kind == VolInfinite)
			return FlagsFull;
		flags = (mode == ModeSegment) ? FlagsPossible : FlagsFull;
		for (int p = 0; p < n; p++) begin
			if (mode == ModePoint) begin
				if (plane_distance(p, ax, ay, az) > 0)
					return FlagsNone;
			end else if (mode == ModeSegment) begin
				if (plane_distance(p, ax, ay, az) > 0 && plane_distance(p, bx, by, bz) > 0)
					return FlagsNone;
			end else if (mode == ModeSphere) begin
				pl_dist = plane_distance(p, ax, ay, az);
				radius = aw * 66'sd16384;
				if (pl_dist > radius)
					return FlagsNone;
				if (pl_dist > -radius)
					flags[2] = 1'b0;
			end else begin
				all_in = 1'b1;
				all_out = 1'b1;
				for (int c = 0; c < 8; c++) begin
					cx = c[0] ? bx : ax;
					cy = c[1] ? by : ay;
					cz = c[2] ? bz : az;
					if (plane_distance(p, cx, cy, cz) < 0)
						all_out = 1'b0;
					else
						all_in = 1'b0;
				end
				if (all_out)
					return FlagsNone;
				if (!all_in)
					flags[2] = 1'b0;
			end
		end
		return flags;
	endfunction

	// transactions on all three channels
	always @(posedge clk or negedge arst_n) begin
		logic [2:0] mode;
		logic [4:0] slot;
		logic [2:0] want;
		if (!arst_n) begin
			used_planes = '0;
			vol_kind = VolNormal;
			expected_flags.delete();
			fail_count = 0;
			flags_pending <= 0;
			flags_checked = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_flags.size() == 0) begin
					report($sformatf("result %0d with none expected", m_axis_tdata[2:0]));
				end else begin
					want = expected_flags.pop_front();
					if (m_axis_tdata[2:0] !== want)
						report($sformatf("intersect_flags %b, expected %b",
							m_axis_tdata[2:0], want));
				end
				flags_checked++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CfgPlaneCount)
					used_planes = cfg_data[5:0];
				else
					vol_kind = cfg_data[1:0];
			end
			if (s_axis_tvalid && s_axis_tready) begin
				mode = s_axis_tdata[2:0];
				slot = s_axis_tdata[7:3];
				if (mode == ModeWrite) begin
					norm_x[slot] = s_axis_tdata[39:8];
					norm_y[slot] = s_axis_tdata[71:40];
					norm_z[slot] = s_axis_tdata[103:72];
					offset[slot] = s_axis_tdata[135:104];
				end else if (mode <= ModeBox) begin
					expected_flags.push_back(containment_flags(mode,
						s_axis_tdata[39:8], s_axis_tdata[71:40], s_axis_tdata[103:72],
						s_axis_tdata[135:104], s_axis_tdata[167:136],
						s_axis_tdata[199:168], s_axis_tdata[231:200]));
				end
			end
			flags_pending <= expected_flags.size();
		end
	end

endmodule

// File: tb/kdop_plane_set_containment_test_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kdop_plane_set_containment_test_core_tb
// loads a cube of planes plus random ones, runs directed point, segment,
// sphere and box queries, then random phases over several plane counts and
// volume kinds with bursty input and a stalling receiver; the checker module
// predicts and compares every result
// ----------------------------------------------------------------------------
module kdop_plane_set_containment_test_core_tb;
	import kdop_pkg::*;

	localparam int CycleLimit = 1500000;
	localparam logic signed [31:0] One = 32'sh0001_0000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [231:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [7:0]   m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [7:0]   cfg_data;
	int           fail_count;
	int           flags_pending;
	int           flags_checked;
	int           cycle_count;
	int           queries_sent;
	logic         long_hold_req;
	logic         long_hold_done;

	kdop_plane_set_containment_test_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	kdop_containment_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.flags_pending (flags_pending),
		.flags_checked (flags_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL kdop_plane_set_containment_test_core");
			$finish;
		end
	end

	// receiver: changing stall pattern, one long hold-off on request
	initial begin
		int pattern;
		m_axis_tready = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req && !long_hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold_done <= 1'b1;
			end
			pattern = $urandom_range(0, 2);
			repeat ($urandom_range(16, 96)) begin
				case (pattern)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 1);
					default: m_axis_tready <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic logic [231:0] item(input int mode, input int slot,
			input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
			input logic [31:0] aw, input logic [31:0] bx, input logic [31:0] by,
			input logic [31:0] bz);
		return {bz, by, bx, aw, az, ay, ax, 5'(slot), 3'(mode)};
	endfunction

	// mostly small coordinates so that queries land near planes
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0;
				default: return 32'hffff_ffff;
			endcase
			default: return $signed($urandom_range(0, 16 << 16)) - (8 << 16);
		endcase
	endfunction

	task automatic send(input logic [231:0] data);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (data[2:0] != ModeWrite && data[2:0] <= ModeBox)
			queries_sent++;
	endtask

	task automatic pause(input int cycles);
		s_axis_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (flags_pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_volume(input int count, input logic [1:0] kind);
		drain();
		write_reg(CfgPlaneCount, 8'(count));
		write_reg(CfgVolumeKind, {6'b0, kind});
	endtask

	function automatic logic [231:0] random_item();
		logic [2:0] mode;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			mode = ModeWrite;
		else if (pick < 12)
			mode = ModeBox + 3'($urandom_range(1, 3));
		else
			mode = 3'($urandom_range(ModePoint, ModeBox));
		if (mode == ModeWrite)
			return item(mode, 5'($urandom), rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), $urandom, $urandom, $urandom);
		return item(mode, 5'($urandom), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord());
	endfunction

	// random items in bursts with gaps
	task automatic random_phase(input int count);
		int left;
		left = count;
		while (left > 0) begin
			repeat ($urandom_range(1, 12)) begin
				if (left > 0) begin
					send(random_item());
					left--;
				end
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 6));
		end
	endtask

	initial begin
		logic signed [31:0] four;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CfgPlaneCount;
		cfg_data = '0;
		cycle_count = 0;
		queries_sent = 0;
		long_hold_req = 1'b0;
		four = 4 * One;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no planes in use: a point query is fully inside
		send(item(ModePoint, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0));

		// a cube of half-size 4 in slots 0..5, random planes above it
		send(item(ModeWrite, 0, One, 0, 0, -four, 0, 0, 0));
		send(item(ModeWrite, 1, -One, 0, 0, -four, 0, 0, 0));
		send(item(ModeWrite, 2, 0, One, 0, -four, 0, 0, 0));
		send(item(ModeWrite, 3, 0, -One, 0, -four, 0, 0, 0));
		send(item(ModeWrite, 4, 0, 0, One, -four, 0, 0, 0));
		send(item(ModeWrite, 5, 0, 0, -One, -four, 0, 0, 0));
		for (int i = 6; i < MaxPlanesDefault; i++)
			send(item(ModeWrite, i, rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), 0, 0, 0));
		set_volume(6, VolNormal);

		// directed queries against the cube
		send(item(ModePoint, 0, 0, 0, 0, 0, 0, 0, 0));
		send(item(ModePoint, 0, four, 0, 0, 0, 0, 0, 0));
		send(item(ModePoint, 0, four + 1, 0, 0, 0, 0, 0, 0));
		send(item(ModeSegment, 0, -8 * One, 0, 0, 0, 8 * One, 0, 0));
		send(item(ModeSegment, 0, 5 * One, 0, 0, 0, 6 * One, 0, 0));
		send(item(ModeSegment, 0, 5 * One, 0, 0, 0, -6 * One, One, 0));
		send(item(ModeSphere, 0, 0, 0, 0, One, 0, 0, 0));
		send(item(ModeSphere, 0, four, 0, 0, One, 0, 0, 0));
		send(item(ModeSphere, 0, 6 * One, 0, 0, One, 0, 0, 0));
		send(item(ModeSphere, 0, 0, 0, 0, -One, 0, 0, 0));
		send(item(ModeBox, 0, -One, -One, -One, 0, One, One, One));
		send(item(ModeBox, 0, 0, 0, 0, 0, 8 * One, One, One));
		send(item(ModeBox, 0, 5 * One, 0, 0, 0, 8 * One, One, One));
		send(item(ModeBox, 0, One, One, One, 0, -One, -One, -One));
		send(item(ModeBox, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		send(item(ModeBox + 1, 0, 0, 0, 0, 0, 0, 0, 0));
		send(item(3'b111, 5'h1f, '1, '1, '1, '1, '1, '1, '1));
		set_volume(6, VolEmpty);
		send(item(ModePoint, 0, 0, 0, 0, 0, 0, 0, 0));
		set_volume(6, VolInfinite);
		send(item(ModeSegment, 0, 5 * One, 0, 0, 0, 6 * One, 0, 0));
		set_volume(6, 2'd3);
		send(item(ModePoint, 0, 6 * One, 0, 0, 0, 0, 0, 0));

		// random phases over plane counts and volume kinds
		set_volume(0, VolNormal);
		random_phase(80);
		set_volume(1, VolNormal);
		random_phase(100);
		set_volume(6, VolNormal);
		random_phase(120);
		long_hold_req <= 1'b1;
		random_phase(60);
		drain();
		random_phase(60);
		set_volume(32, VolNormal);
		random_phase(100);
		set_volume(63, 2'd3);
		random_phase(80);
		set_volume(8'hff, VolEmpty);
		random_phase(50);
		set_volume($urandom_range(2, 31), VolInfinite);
		random_phase(50);
		set_volume($urandom_range(0, 255), VolNormal);
		random_phase(100);
		set_volume($urandom_range(1, 12), VolNormal);
		random_phase(100);

		drain();
		repeat (40) @(posedge clk);
		$display("covered %0d queries, %0d results checked, cube and random planes",
			queries_sent, flags_checked);
		$display("plane counts 0 to 63 and all four volume kinds, with stalls on both sides");
		if (flags_pending != 0)
			$display("%0d expected results never arrived", flags_pending);
		if (fail_count == 0 && flags_pending == 0) begin
			$display("PASS kdop_plane_set_containment_test_core");
		end else begin
			$display("FAIL kdop_plane_set_containment_test_core");
		end
		$finish;
	end

endmodule
